FILE: sv/oah_pkg.sv
`timescale 1ns / 1ps
// shared types and codes of the open-addressing hash insert block
package oah_pkg;

  // width of the table size register and of slot positions within it
  localparam int SIZE_W = 7;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_LOAD    = 2'd1,
    ST_NO_FREE = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_READ   = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    PM_LINEAR    = 2'd0,
    PM_QUADRATIC = 2'd1,
    PM_DOUBLE    = 2'd2,
    PM_BAD       = 2'd3
  } method_t;

  // reset value of the table size register
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd10;

endpackage

FILE: sv/oah_if.sv
`timescale 1ns / 1ps
// channel interfaces: request, response and configuration write

interface oah_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [1:0]  probe_method;
  logic [63:0] key_text;
  logic [63:0] value_text;
  logic [5:0]  slot_index;
  modport source (output valid, req_type, probe_method, key_text, value_text, slot_index,
                  input ready);
  modport sink   (input valid, req_type, probe_method, key_text, value_text, slot_index,
                  output ready);
endinterface

interface oah_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  slot;
  logic        occupied;
  logic [63:0] stored_key;
  logic [63:0] stored_value;
  logic [6:0]  probe_count;
  modport source (output valid, status, slot, occupied, stored_key, stored_value, probe_count,
                  input ready);
  modport sink   (input valid, status, slot, occupied, stored_key, stored_value, probe_count,
                  output ready);
endinterface

interface oah_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: sv/oah_hash.sv
`timescale 1ns / 1ps
// key hash: shift-and-add over key bytes, then bit-serial reduction by table size
module oah_hash #(
  parameter int KEY_CHARS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [63:0]              key,
  input  logic [oah_pkg::SIZE_W-1:0] size,
  output logic                     done,
  output logic [oah_pkg::SIZE_W-1:0] home
);
  import oah_pkg::*;

  localparam int N_W = $clog2(KEY_CHARS + 1);

  typedef enum logic [1:0] {H_IDLE, H_BYTES, H_MOD} hstate_t;

  hstate_t           state;
  logic [63:0]       key_sh;
  logic [31:0]       h;
  logic [N_W-1:0]    n;
  logic [4:0]        bit_cnt;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W:0]   rem_sh;
  logic [7:0]        byte_top;

  assign byte_top = key_sh[63:56];
  assign rem_sh   = {rem, h[31]};

  // one byte per cycle, then one dividend bit per cycle
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= H_IDLE;
    end else begin
      case (state)
        H_IDLE: begin
          if (start) begin
            key_sh <= key;
            h      <= '0;
            n      <= '0;
            state  <= H_BYTES;
          end
        end
        H_BYTES: begin
          if (byte_top == 8'd0 || n == N_W'(KEY_CHARS)) begin
            rem     <= '0;
            bit_cnt <= '0;
            state   <= H_MOD;
          end else begin
            h      <= (h << 5) + {24'd0, byte_top};
            key_sh <= key_sh << 8;
            n      <= n + 1'b1;
          end
        end
        H_MOD: begin
          if (rem_sh >= {1'b0, size}) begin
            rem <= SIZE_W'(rem_sh - {1'b0, size});
          end else begin
            rem <= rem_sh[SIZE_W-1:0];
          end
          h       <= h << 1;
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == 5'd31) begin
            done  <= 1'b1;
            state <= H_IDLE;
          end
        end
        default: state <= H_IDLE;
      endcase
    end
  end

  assign home = rem;

endmodule

FILE: sv/open_addressing_hash_insert.sv
`timescale 1ns / 1ps
// open-addressing hash table with insert and slot read requests
//
// req carries one request beat: insert a key and value, or read one slot.
// rsp returns exactly one result beat per request, in order.
// cfg writes the table size (slots in use, 0 acts as 1, above CAPACITY
// acts as CAPACITY); write only while no request is in flight.
// An insert hashes one key byte per cycle (up to KEY_CHARS) and then stops,
// reduces the hash by the table size one bit per cycle, hands over and sets
// up the probe step, tests one probe slot per cycle (up to MAX_PROBES slots),
// then loads the result beat. A read waits in S_READ for the registered
// memory read before its result is loaded. Refused inserts and bad
// requests go straight to loading the result.
// One request is worked on at a time; the next is taken once the block is
// idle, even while a result still waits in the output register.
// Reset clears all occupied flags, the entry count and the size (to 10).
// A stalled receiver holds the result; the next finished result waits.
module open_addressing_hash_insert #(
  parameter int CAPACITY   = 64,
  parameter int MAX_PROBES = 64,
  parameter int KEY_CHARS  = 8
) (
  input  logic       clk,
  input  logic       rst,
  oah_req_if.sink    req,
  oah_rsp_if.source  rsp,
  oah_cfg_if.sink    cfg
);
  import oah_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int PC_W  = $clog2(MAX_PROBES + 1);

  typedef enum logic [2:0] {S_IDLE, S_HASH, S_PREP, S_PROBE, S_READ, S_FIN} state_t;

  // restoring mod 7 of a narrow value
  function automatic logic [2:0] mod7(input logic [SIZE_W-1:0] v);
    logic [SIZE_W+2:0] r;
    r = {3'd0, v};
    for (int k = 4; k >= 0; k--) begin
      if (r >= ((SIZE_W+3)'(7) << k)) r = r - ((SIZE_W+3)'(7) << k);
    end
    return r[2:0];
  endfunction

  // step (1..7) reduced by the table size
  function automatic logic [SIZE_W-1:0] mod_size(input logic [2:0] v,
                                                  input logic [SIZE_W-1:0] s);
    logic [SIZE_W+2:0] r;
    r = {{SIZE_W{1'b0}}, v};
    for (int k = 2; k >= 0; k--) begin
      if (r >= ({3'd0, s} << k)) r = r - ({3'd0, s} << k);
    end
    return r[SIZE_W-1:0];
  endfunction

  state_t              state;
  logic [SIZE_W-1:0]   table_size;
  logic [SIZE_W-1:0]   size;
  logic [CAPACITY-1:0] used;
  logic [6:0]          entry_count;
  logic [127:0]        mem [CAPACITY];
  logic [127:0]        rdata;
  logic [IDX_W-1:0]    rd_addr;

  logic [63:0]         key;
  logic [63:0]         val;
  logic [1:0]          method;
  logic [SIZE_W-1:0]   p;
  logic [SIZE_W-1:0]   d;
  logic [PC_W-1:0]     i;
  logic                is_read;

  status_t             res_status;
  logic [5:0]          res_slot;
  logic                res_occ;
  logic [6:0]          res_probes;

  logic                accept;
  logic                hash_start;
  logic                hash_done;
  logic [SIZE_W-1:0]   home;
  logic                load_full;
  logic                bad_read;
  logic [2:0]          dstep;
  logic [SIZE_W:0]     p_sum;
  logic [SIZE_W-1:0]   p_next;
  logic [SIZE_W:0]     d_sum;
  logic [SIZE_W:0]     d_red;
  logic [SIZE_W-1:0]   d_next;
  logic                mem_we;
  logic [IDX_W-1:0]    p_idx;

  // effective table size
  always_comb begin
    size = table_size;
    if (table_size == '0) size = SIZE_W'(1);
    if (CAPACITY < (1 << SIZE_W) && table_size > SIZE_W'(CAPACITY)) size = SIZE_W'(CAPACITY);
  end

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign load_full  = ({7'd0, entry_count} * 14'd100) >= ({7'd0, size} * 14'd65);
  assign bad_read   = {1'b0, req.slot_index} >= {1'b0, size};
  assign hash_start = accept && req.req_type == REQ_INSERT &&
                      req.probe_method != PM_BAD && !load_full;

  oah_hash #(.KEY_CHARS(KEY_CHARS)) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (req.key_text),
    .size  (size),
    .done  (hash_done),
    .home  (home)
  );

  // next probe position and quadratic increment, each reduced by the size
  assign dstep  = 3'd7 - mod7(home);
  assign p_idx  = IDX_W'(p);
  assign p_sum  = {1'b0, p} + {1'b0, d};
  assign p_next = (p_sum >= {1'b0, size}) ? SIZE_W'(p_sum - {1'b0, size}) : p_sum[SIZE_W-1:0];
  assign d_sum  = {1'b0, d} + (SIZE_W+1)'(2);
  assign d_red  = (d_sum >= {1'b0, size}) ? d_sum - {1'b0, size} : d_sum;
  assign d_next = (d_red >= {1'b0, size}) ? SIZE_W'(d_red - {1'b0, size}) : d_red[SIZE_W-1:0];

  assign mem_we = (state == S_PROBE) && !used[p_idx];

  // key and value store
  always_ff @(posedge clk) begin
    if (mem_we) mem[p_idx] <= {key, val};
    rdata <= mem[rd_addr];
  end

  // control and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      table_size  <= SIZE_RESET;
      used        <= '0;
      entry_count <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) table_size <= cfg.data;
      // result beat taken and no new one loaded behind it
      if (rsp.valid && rsp.ready && state != S_FIN) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            key        <= req.key_text;
            val        <= req.value_text;
            method     <= req.probe_method;
            is_read    <= (req.req_type == REQ_READ);
            rd_addr    <= IDX_W'(req.slot_index);
            res_slot   <= '0;
            res_occ    <= 1'b0;
            res_probes <= '0;
            res_status <= ST_DONE;
            if (req.req_type == REQ_READ) begin
              res_slot <= req.slot_index;
              if (bad_read) begin
                res_status <= ST_BAD;
                is_read    <= 1'b0;
                state      <= S_FIN;
              end else begin
                res_occ <= used[IDX_W'(req.slot_index)];
                state   <= S_READ;
              end
            end else if (req.probe_method == PM_BAD) begin
              res_status <= ST_BAD;
              state      <= S_FIN;
            end else if (load_full) begin
              res_status <= ST_LOAD;
              state      <= S_FIN;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) state <= S_PREP;
        end
        S_PREP: begin
          p <= home;
          i <= '0;
          case (method)
            PM_DOUBLE: d <= mod_size(dstep, size);
            default:   d <= (size == SIZE_W'(1)) ? '0 : SIZE_W'(1);
          endcase
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (!used[p_idx]) begin
            used[p_idx] <= 1'b1;
            if (entry_count != 7'd127) entry_count <= entry_count + 1'b1;
            res_status <= ST_DONE;
            res_slot   <= 6'(p);
            res_occ    <= 1'b1;
            res_probes <= 7'(i);
            state      <= S_FIN;
          end else if (i == PC_W'(MAX_PROBES - 1)) begin
            res_status <= ST_NO_FREE;
            res_probes <= 7'(MAX_PROBES);
            state      <= S_FIN;
          end else begin
            p <= p_next;
            if (method == PM_QUADRATIC) d <= d_next;
            i <= i + 1'b1;
          end
        end
        S_READ: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.status      <= res_status;
            rsp.slot        <= res_slot;
            rsp.occupied    <= res_occ;
            rsp.probe_count <= res_probes;
            if (is_read) begin
              rsp.stored_key   <= res_occ ? rdata[127:64] : 64'd0;
              rsp.stored_value <= res_occ ? rdata[63:0] : 64'd0;
            end else begin
              rsp.stored_key   <= res_occ ? key : 64'd0;
              rsp.stored_value <= res_occ ? val : 64'd0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
